### sv/assert_macros.svh
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion lbl failed");

// next-cycle implication
`define ASSERT_NXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion lbl failed");

`endif

### sv/cpt_pkg.sv
package cpt_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int DIFF_W      = COORD_WIDTH + 1;
  localparam int DOT_W       = 2 * DIFF_W + 2;
  localparam int LIMB_W      = 32;
  localparam int MUL_LAT     = 3;
  localparam int INSIDE_LAT  = 4 + 2 * MUL_LAT;
  localparam int EDGE_LAT    = 5 + 3 * MUL_LAT + DIFF_W;
  localparam int TOTAL_LAT   = EDGE_LAT + 1;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  // [0] x, [1] y, [2] z
  typedef logic [2:0][COORD_WIDTH-1:0] vec_t;

  typedef struct packed {
    coord_t vertex0_x;
    coord_t vertex0_y;
    coord_t vertex0_z;
    coord_t vertex1_x;
    coord_t vertex1_y;
    coord_t vertex1_z;
    coord_t vertex2_x;
    coord_t vertex2_y;
    coord_t vertex2_z;
    coord_t point_x;
    coord_t point_y;
    coord_t point_z;
  } cpt_in_t;

  typedef struct packed {
    coord_t nearest_x;
    coord_t nearest_y;
    coord_t nearest_z;
    logic   inside_flag;
  } cpt_out_t;

  typedef struct packed {
    logic             valid;
    vec_t             c;
    logic [DOT_W-1:0] dist_sq;
  } edge_res_t;

endpackage

### sv/cpt_mul.sv
// Signed multiplier built from limb products: products, row sums, total.
module cpt_mul #(
  parameter int AW = 33,
  parameter int BW = 33
) (
  input  logic                 clk,
  input  logic signed [AW-1:0] a,
  input  logic signed [BW-1:0] b,
  output logic signed [AW+BW-1:0] p
);

  localparam int LW = cpt_pkg::LIMB_W;
  localparam int NA = (AW + LW - 1) / LW;
  localparam int NB = (BW + LW - 1) / LW;
  localparam int RW = AW + BW;

  logic signed [NA*LW-1:0] ax;
  logic signed [NB*LW-1:0] bx;
  logic signed [LW:0]      al [NA];
  logic signed [LW:0]      bl [NB];
  logic signed [2*LW+1:0]  pp [NA][NB];
  logic signed [RW-1:0]    row [NA];
  logic signed [RW-1:0]    row_next [NA];
  logic signed [RW-1:0]    p_next;

  assign ax = (NA*LW)'(a);
  assign bx = (NB*LW)'(b);

  // top limb carries the sign, lower limbs are unsigned
  for (genvar i = 0; i < NA; i++) begin : g_al
    if (i == NA - 1) begin : g_top
      assign al[i] = {ax[NA*LW-1], ax[i*LW +: LW]};
    end else begin : g_low
      assign al[i] = {1'b0, ax[i*LW +: LW]};
    end
  end
  for (genvar j = 0; j < NB; j++) begin : g_bl
    if (j == NB - 1) begin : g_top
      assign bl[j] = {bx[NB*LW-1], bx[j*LW +: LW]};
    end else begin : g_low
      assign bl[j] = {1'b0, bx[j*LW +: LW]};
    end
  end

  always_comb begin
    for (int i = 0; i < NA; i++) begin
      row_next[i] = '0;
      for (int j = 0; j < NB; j++) begin
        row_next[i] = row_next[i] + (RW'(pp[i][j]) << (LW * j));
      end
    end
    p_next = '0;
    for (int i = 0; i < NA; i++) begin
      p_next = p_next + (row[i] << (LW * i));
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        pp[i][j] <= al[i] * bl[j];
      end
      row[i] <= row_next[i];
    end
    p <= p_next;
  end

endmodule

### sv/cpt_div.sv
// Pipelined restoring divider, one quotient bit per stage, MSB first.
// Quotient must fit in QW bits.
module cpt_div #(
  parameter int NW = 103,
  parameter int DW = 69,
  parameter int QW = 33
) (
  input  logic          clk,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo
);

  logic [NW-1:0] rem [1:QW-1];
  logic [DW-1:0] dv  [1:QW-1];
  logic [QW-1:0] qs  [1:QW];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic [NW-1:0] r_in;
    logic [DW-1:0] d_in;
    logic [QW-1:0] q_in;
    logic [NW:0]   trial;

    if (s == 0) begin : g_first
      assign r_in = num;
      assign d_in = den;
      assign q_in = '0;
    end else begin : g_rest
      assign r_in = rem[s];
      assign d_in = dv[s];
      assign q_in = qs[s];
    end

    assign trial = {1'b0, r_in} - ({1'b0, NW'(d_in)} << (QW - 1 - s));

    always_ff @(posedge clk) begin
      qs[s+1] <= {q_in[QW-2:0], ~trial[NW]};
    end

    if (s < QW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        rem[s+1] <= trial[NW] ? r_in : trial[NW-1:0];
        dv[s+1]  <= d_in;
      end
    end
  end

  assign quo = qs[QW];

endmodule

### sv/cpt_inside.sv
// Barycentric inside test with exact Gram determinants.
module cpt_inside (
  input  logic             clk,
  input  cpt_pkg::cpt_in_t request,
  output logic             hit
);

  localparam int DW = cpt_pkg::DIFF_W;
  localparam int PW = cpt_pkg::DOT_W;
  localparam int GW = 2 * PW + 1;

  cpt_pkg::coord_t v0 [3];
  cpt_pkg::coord_t v1 [3];
  cpt_pkg::coord_t v2 [3];
  cpt_pkg::coord_t pt [3];

  logic signed [DW-1:0]   e0 [3];
  logic signed [DW-1:0]   e1 [3];
  logic signed [DW-1:0]   e2 [3];
  logic signed [2*DW-1:0] p00 [3];
  logic signed [2*DW-1:0] p01 [3];
  logic signed [2*DW-1:0] p02 [3];
  logic signed [2*DW-1:0] p11 [3];
  logic signed [2*DW-1:0] p12 [3];

  logic signed [PW-1:0]   d00, d01, d02, d11, d12;
  logic signed [2*PW-1:0] m_a, m_b, m_c, m_d, m_e, m_f;
  logic signed [GW-1:0]   den, nu, nv;
  logic signed [GW+1:0]   slack;

  assign v0[0] = request.vertex0_x;
  assign v0[1] = request.vertex0_y;
  assign v0[2] = request.vertex0_z;
  assign v1[0] = request.vertex1_x;
  assign v1[1] = request.vertex1_y;
  assign v1[2] = request.vertex1_z;
  assign v2[0] = request.vertex2_x;
  assign v2[1] = request.vertex2_y;
  assign v2[2] = request.vertex2_z;
  assign pt[0] = request.point_x;
  assign pt[1] = request.point_y;
  assign pt[2] = request.point_z;

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      e0[k] <= DW'(v1[k]) - DW'(v0[k]);
      e1[k] <= DW'(v2[k]) - DW'(v0[k]);
      e2[k] <= DW'(pt[k]) - DW'(v0[k]);
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_dot
    cpt_mul #(.AW(DW), .BW(DW)) u_m00 (.clk(clk), .a(e0[k]), .b(e0[k]), .p(p00[k]));
    cpt_mul #(.AW(DW), .BW(DW)) u_m01 (.clk(clk), .a(e0[k]), .b(e1[k]), .p(p01[k]));
    cpt_mul #(.AW(DW), .BW(DW)) u_m02 (.clk(clk), .a(e0[k]), .b(e2[k]), .p(p02[k]));
    cpt_mul #(.AW(DW), .BW(DW)) u_m11 (.clk(clk), .a(e1[k]), .b(e1[k]), .p(p11[k]));
    cpt_mul #(.AW(DW), .BW(DW)) u_m12 (.clk(clk), .a(e1[k]), .b(e2[k]), .p(p12[k]));
  end

  always_ff @(posedge clk) begin
    d00 <= PW'(p00[0]) + PW'(p00[1]) + PW'(p00[2]);
    d01 <= PW'(p01[0]) + PW'(p01[1]) + PW'(p01[2]);
    d02 <= PW'(p02[0]) + PW'(p02[1]) + PW'(p02[2]);
    d11 <= PW'(p11[0]) + PW'(p11[1]) + PW'(p11[2]);
    d12 <= PW'(p12[0]) + PW'(p12[1]) + PW'(p12[2]);
  end

  cpt_mul #(.AW(PW), .BW(PW)) u_ma (.clk(clk), .a(d00), .b(d11), .p(m_a));
  cpt_mul #(.AW(PW), .BW(PW)) u_mb (.clk(clk), .a(d01), .b(d01), .p(m_b));
  cpt_mul #(.AW(PW), .BW(PW)) u_mc (.clk(clk), .a(d11), .b(d02), .p(m_c));
  cpt_mul #(.AW(PW), .BW(PW)) u_md (.clk(clk), .a(d01), .b(d12), .p(m_d));
  cpt_mul #(.AW(PW), .BW(PW)) u_me (.clk(clk), .a(d00), .b(d12), .p(m_e));
  cpt_mul #(.AW(PW), .BW(PW)) u_mf (.clk(clk), .a(d01), .b(d02), .p(m_f));

  assign slack = (GW+2)'(den) - (GW+2)'(nu) - (GW+2)'(nv);

  always_ff @(posedge clk) begin
    den <= GW'(m_a) - GW'(m_b);
    nu  <= GW'(m_c) - GW'(m_d);
    nv  <= GW'(m_e) - GW'(m_f);
    // zero determinant (degenerate) never counts as inside
    hit <= (den > 0) && (nu >= 0) && (nv >= 0) && (slack >= 0);
  end

endmodule

### sv/cpt_edge.sv
// Projection of the point onto one segment a->b, clamped, plus squared distance.
module cpt_edge (
  input  logic               clk,
  input  logic               rst,
  input  logic               valid_in,
  input  cpt_pkg::vec_t      a_in,
  input  cpt_pkg::vec_t      b_in,
  input  cpt_pkg::vec_t      p_in,
  output cpt_pkg::edge_res_t res
);

  localparam int W    = cpt_pkg::COORD_WIDTH;
  localparam int DW   = cpt_pkg::DIFF_W;
  localparam int PW   = cpt_pkg::DOT_W;
  localparam int ML   = cpt_pkg::MUL_LAT;
  localparam int QB   = DW;
  localparam int MW   = DW + 1 + PW;
  localparam int TW   = MW + 1;
  localparam int S_DOT = 2 + ML;
  localparam int S_M   = 2 + 2 * ML;
  localparam int S_Q   = 3 + 2 * ML + QB;
  localparam int S_C   = S_Q + 1;
  localparam int S_D   = S_C + ML + 1;

  localparam logic signed [W+1:0] CMAX = {3'b000, {(W-1){1'b1}}};
  localparam logic signed [W+1:0] CMIN = {3'b111, {(W-1){1'b0}}};

  typedef struct packed {
    logic                valid;
    cpt_pkg::vec_t       a;
    cpt_pkg::vec_t       b;
    cpt_pkg::vec_t       p;
    logic [2:0][DW-1:0]  ab;
  } side_t;

  typedef struct packed {
    logic          take_a;
    logic          take_b;
    logic [PW-1:0] len;
  } fl_t;

  typedef struct packed {
    logic          valid;
    cpt_pkg::vec_t c;
  } cd_t;

  side_t sd_in;
  side_t sd [1:S_C];
  fl_t   fl_in;
  fl_t   fl [S_DOT+1:S_Q];
  cd_t   cd [S_C+1:S_D];

  logic signed [DW-1:0]   ap [3];
  logic signed [2*DW-1:0] pn [3];
  logic signed [2*DW-1:0] pl [3];
  logic signed [PW-1:0]   num, len;
  logic        [DW-1:0]   mag [3];
  logic signed [MW-1:0]   m [3];
  logic        [TW-1:0]   t [3];
  logic        [PW:0]     dv;
  logic        [QB-1:0]   q [3];
  logic signed [W+1:0]    csum [3];
  cpt_pkg::coord_t        cn [3];
  cpt_pkg::vec_t          c;
  logic signed [DW-1:0]   dvec [3];
  logic signed [2*DW-1:0] sq [3];
  logic        [PW-1:0]   dist_sq;

  always_comb begin
    sd_in.valid = valid_in;
    sd_in.a     = a_in;
    sd_in.b     = b_in;
    sd_in.p     = p_in;
    for (int k = 0; k < 3; k++) begin
      sd_in.ab[k] = DW'($signed(b_in[k])) - DW'($signed(a_in[k]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int n = 1; n <= S_C; n++) sd[n].valid <= 1'b0;
    end else begin
      sd[1] <= sd_in;
      for (int n = 2; n <= S_C; n++) sd[n] <= sd[n-1];
    end
    for (int k = 0; k < 3; k++) begin
      ap[k] <= DW'($signed(p_in[k])) - DW'($signed(a_in[k]));
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_dot
    cpt_mul #(.AW(DW), .BW(DW)) u_num (
      .clk(clk), .a(ap[k]), .b($signed(sd[1].ab[k])), .p(pn[k]));
    cpt_mul #(.AW(DW), .BW(DW)) u_len (
      .clk(clk), .a($signed(sd[1].ab[k])), .b($signed(sd[1].ab[k])), .p(pl[k]));
  end

  always_ff @(posedge clk) begin
    num <= PW'(pn[0]) + PW'(pn[1]) + PW'(pn[2]);
    len <= PW'(pl[0]) + PW'(pl[1]) + PW'(pl[2]);
  end

  // zero-length edge or point behind a: start vertex; past b: end vertex
  always_comb begin
    fl_in.take_a = (len == '0) || (num <= 0);
    fl_in.take_b = (num >= len);
    fl_in.len    = len;
  end

  always_ff @(posedge clk) begin
    fl[S_DOT+1] <= fl_in;
    for (int n = S_DOT + 2; n <= S_Q; n++) fl[n] <= fl[n-1];
  end

  for (genvar k = 0; k < 3; k++) begin : g_scale
    assign mag[k] = sd[S_DOT].ab[k][DW-1] ? -sd[S_DOT].ab[k] : sd[S_DOT].ab[k];

    cpt_mul #(.AW(DW + 1), .BW(PW)) u_mag (
      .clk(clk), .a($signed({1'b0, mag[k]})), .b(num), .p(m[k]));

    // round half up: (2m + len) / (2 len)
    always_ff @(posedge clk) begin
      t[k] <= (TW'($unsigned(m[k])) << 1) + TW'(fl[S_M].len);
    end

    cpt_div #(.NW(TW), .DW(PW + 1), .QW(QB)) u_div (
      .clk(clk), .num(t[k]), .den(dv), .quo(q[k]));
  end

  always_ff @(posedge clk) begin
    dv <= {fl[S_M].len, 1'b0};
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (sd[S_Q].ab[k][DW-1]) begin
        csum[k] = (W+2)'($signed(sd[S_Q].a[k])) - (W+2)'(q[k]);
      end else begin
        csum[k] = (W+2)'($signed(sd[S_Q].a[k])) + (W+2)'(q[k]);
      end
      if (fl[S_Q].take_a) begin
        cn[k] = sd[S_Q].a[k];
      end else if (fl[S_Q].take_b) begin
        cn[k] = sd[S_Q].b[k];
      end else if (csum[k] > CMAX) begin
        cn[k] = CMAX[W-1:0];
      end else if (csum[k] < CMIN) begin
        cn[k] = CMIN[W-1:0];
      end else begin
        cn[k] = csum[k][W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) c[k] <= cn[k];
  end

  for (genvar k = 0; k < 3; k++) begin : g_dist
    assign dvec[k] = DW'($signed(c[k])) - DW'($signed(sd[S_C].p[k]));
    cpt_mul #(.AW(DW), .BW(DW)) u_sq (.clk(clk), .a(dvec[k]), .b(dvec[k]), .p(sq[k]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int n = S_C + 1; n <= S_D; n++) cd[n].valid <= 1'b0;
    end else begin
      cd[S_C+1] <= {sd[S_C].valid, c};
      for (int n = S_C + 2; n <= S_D; n++) cd[n] <= cd[n-1];
    end
    dist_sq <= PW'($unsigned(sq[0])) + PW'($unsigned(sq[1])) + PW'($unsigned(sq[2]));
  end

  assign res.valid   = cd[S_D].valid;
  assign res.c       = cd[S_D].c;
  assign res.dist_sq = dist_sq;

endmodule

### sv/closest_point_on_triangle.sv
// Throughput: one item per cycle while rst is low; the per-coordinate edge dividers (one bit per
// stage) set the depth, every stage is registered and never holds.
// busy is high only while rst is high; results cannot be stalled by the receiver.
// Synchronous reset clears all valid bits; items in flight are dropped.
`include "assert_macros.svh"

module closest_point_on_triangle (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  cpt_pkg::cpt_in_t  request,
  output logic              busy,
  output logic              done,
  output cpt_pkg::cpt_out_t result
);

  localparam int LI = cpt_pkg::INSIDE_LAT;
  localparam int LE = cpt_pkg::EDGE_LAT;

  logic               accept;
  cpt_pkg::vec_t      v0, v1, v2, pt;
  cpt_pkg::edge_res_t r0, r1, r2;
  logic               in_face;
  logic               ins [LI+1:LE];
  cpt_pkg::vec_t      pd  [1:LE];
  cpt_pkg::vec_t      pick;
  cpt_pkg::cpt_out_t  result_next;

  assign busy   = rst;
  assign accept = start && !busy;

  assign v0 = {request.vertex0_z, request.vertex0_y, request.vertex0_x};
  assign v1 = {request.vertex1_z, request.vertex1_y, request.vertex1_x};
  assign v2 = {request.vertex2_z, request.vertex2_y, request.vertex2_x};
  assign pt = {request.point_z, request.point_y, request.point_x};

  cpt_inside u_inside (.clk(clk), .request(request), .hit(in_face));

  cpt_edge u_edge0 (.clk(clk), .rst(rst), .valid_in(accept),
                    .a_in(v0), .b_in(v1), .p_in(pt), .res(r0));
  cpt_edge u_edge1 (.clk(clk), .rst(rst), .valid_in(accept),
                    .a_in(v1), .b_in(v2), .p_in(pt), .res(r1));
  cpt_edge u_edge2 (.clk(clk), .rst(rst), .valid_in(accept),
                    .a_in(v2), .b_in(v0), .p_in(pt), .res(r2));

  always_ff @(posedge clk) begin
    ins[LI+1] <= in_face;
    for (int n = LI + 2; n <= LE; n++) ins[n] <= ins[n-1];
    pd[1] <= pt;
    for (int n = 2; n <= LE; n++) pd[n] <= pd[n-1];
  end

  // ties go to the earlier edge
  always_comb begin
    if (r1.dist_sq >= r0.dist_sq && r2.dist_sq >= r0.dist_sq) begin
      pick = r0.c;
    end else if (r2.dist_sq >= r1.dist_sq) begin
      pick = r1.c;
    end else begin
      pick = r2.c;
    end
    if (ins[LE]) pick = pd[LE];
    result_next.nearest_x   = pick[0];
    result_next.nearest_y   = pick[1];
    result_next.nearest_z   = pick[2];
    result_next.inside_flag = ins[LE];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= r0.valid;
    end
    result <= result_next;
  end

  `ASSERT_IMP(a_latency, clk, rst, done, $past(start && !busy, cpt_pkg::TOTAL_LAT))
  `ASSERT_IMP(a_inside_pt, clk, rst, done && result.inside_flag,
              result.nearest_x == $past(request.point_x, cpt_pkg::TOTAL_LAT))
  `ASSERT_NXT(a_reset_quiet, clk, 1'b0, rst, !done)

endmodule
